>>> sv/mcdb_pkg.sv
package mcdb_pkg;

  // default channel count and fixed field widths
  localparam int CHANNELS_DEF = 32;
  localparam int CH_W         = 5;
  localparam int TIME_W       = 32;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;

  // register reset values in milliseconds
  localparam logic [TIME_W-1:0] FILTER_FAST_RST = TIME_W'(15000);
  localparam logic [TIME_W-1:0] FILTER_SLOW_RST = TIME_W'(900000);
  localparam logic [TIME_W-1:0] LONG_PRESS_RST  = TIME_W'(5000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVERT_MASK        = 3'd0,
    REG_FILTER_ENABLE_MASK = 3'd1,
    REG_SLOW_FILTER_MASK   = 3'd2,
    REG_FILTER_TIME_FAST   = 3'd3,
    REG_FILTER_TIME_SLOW   = 3'd4,
    REG_LONG_PRESS_MASK    = 3'd5,
    REG_LONG_PRESS_TIME    = 3'd6
  } cfg_reg_t;

  // per-channel state entry held in the state ram
  typedef struct packed {
    logic              raw_level;
    logic [TIME_W-1:0] filter_start;
    logic              debounced_level;
    logic [TIME_W-1:0] press_start;
    logic              long_press_flag;
  } mcdb_entry_t;

  // per-channel settings picked from the registers for one item
  typedef struct packed {
    logic              filter_en;
    logic [TIME_W-1:0] limit;
    logic [TIME_W-1:0] hold;
  } mcdb_chan_cfg_t;

  // edge flags produced by one update
  typedef struct packed {
    logic rise;
    logic fall;
  } mcdb_edges_t;

endpackage

>>> sv/mcdb_if.sv
// input sample channel
interface mcdb_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  channel;
  logic        pin_level;
  logic [31:0] now_ms;

  modport source (output valid, channel, pin_level, now_ms, input ready);
  modport sink (input valid, channel, pin_level, now_ms, output ready);
endinterface

// result channel
interface mcdb_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] out_channel;
  logic       qualified_level;
  logic       long_pressed;
  logic       rising_edge;
  logic       falling_edge;

  modport source (output valid, out_channel, qualified_level, long_pressed, rising_edge,
                  falling_edge, input ready);
  modport sink (input valid, out_channel, qualified_level, long_pressed, rising_edge,
                falling_edge, output ready);
endinterface

>>> sv/mcdb_ram.sv
module mcdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/mcdb_update.sv
module mcdb_update (
  input  mcdb_pkg::mcdb_entry_t            cur,
  input  logic                             level,
  input  logic [mcdb_pkg::TIME_W-1:0]      now,
  input  mcdb_pkg::mcdb_chan_cfg_t         ccfg,
  output mcdb_pkg::mcdb_entry_t            nxt,
  output mcdb_pkg::mcdb_edges_t            edges
);

  import mcdb_pkg::*;

  logic [TIME_W-1:0] filt_age;
  logic [TIME_W-1:0] press_age;
  logic              q;

  always_comb begin
    nxt = cur;

    // raw change restarts the filter timer
    if (level != cur.raw_level) begin
      nxt.filter_start = now;
      nxt.raw_level    = level;
    end
    filt_age = now - nxt.filter_start;

    // qualify the level
    q = cur.debounced_level;
    if (ccfg.filter_en) begin
      if (q != level && filt_age >= ccfg.limit) begin
        q = level;
      end
    end else begin
      q = level;
    end

    // qualified change gives an edge and restarts the press timer
    edges.rise = 1'b0;
    edges.fall = 1'b0;
    if (q != cur.debounced_level) begin
      edges.rise          = q;
      edges.fall          = ~q;
      nxt.debounced_level = q;
      nxt.press_start     = now;
    end
    press_age = now - nxt.press_start;

    // long press: clear on release, set after hold time
    if (cur.long_press_flag != q) begin
      if (!q) begin
        nxt.long_press_flag = 1'b0;
      end else if (press_age >= ccfg.hold) begin
        nxt.long_press_flag = 1'b1;
      end
    end
  end

endmodule

>>> sv/multichannel_input_debounce_longpress_core.sv
// Debounce and long-press detector for up to CHANNELS inputs sampled one item at a time.
// One item is taken every clock cycle unless stalled; its result moves through the stage 1
// and output registers. Per-channel state (raw level, filter start time, debounced level,
// press start time, long-press flag) sits in one ram entry per channel with a registered
// read; each item reads its entry on transfer and writes the update back on leaving stage 1,
// and a same-channel item right behind it gets that update by forwarding. After reset every
// entry reads as zero via per-channel valid flags, so no clearing pass is needed. Channels
// at or above CHANNELS leave state alone and return zeros. Configuration registers are to
// be written through the plain write port only while the block is idle; it is not enforced.
module multichannel_input_debounce_longpress_core #(
  parameter int CHANNELS = mcdb_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mcdb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcdb_pkg::CFG_W-1:0]     cfg_data,
  mcdb_in_if.sink                        in_ch,
  mcdb_out_if.source                     out_ch
);

  import mcdb_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

  // configuration registers
  logic [CFG_W-1:0]  invert_mask;
  logic [CFG_W-1:0]  filter_enable_mask;
  logic [CFG_W-1:0]  slow_filter_mask;
  logic [TIME_W-1:0] filter_time_fast;
  logic [TIME_W-1:0] filter_time_slow;
  logic [CFG_W-1:0]  long_press_mask;
  logic [TIME_W-1:0] long_press_time;

  // stage 1 (ram data returns here)
  logic              s1_v;
  logic [CH_W-1:0]   s1_ch;
  logic              s1_pin;
  logic [TIME_W-1:0] s1_now;
  logic              s1_fwd;

  // output register
  logic              o_v;
  logic [CH_W-1:0]   o_ch;
  logic              o_q;
  logic              o_lp;
  logic              o_rise;
  logic              o_fall;

  logic [CHANNELS-1:0] valid;
  mcdb_entry_t         fwd_entry;
  mcdb_entry_t         ram_rdata;
  mcdb_entry_t         cur;
  mcdb_entry_t         nxt;
  mcdb_chan_cfg_t      ccfg;
  mcdb_edges_t         edges;
  logic                level;
  logic                s1_in_range;
  logic [AW-1:0]       s1_addr;
  logic                advance;
  logic                in_xfer;
  logic                wr;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_mask        <= '0;
      filter_enable_mask <= '0;
      slow_filter_mask   <= '0;
      filter_time_fast   <= FILTER_FAST_RST;
      filter_time_slow   <= FILTER_SLOW_RST;
      long_press_mask    <= '0;
      long_press_time    <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INVERT_MASK:        invert_mask        <= cfg_data;
        REG_FILTER_ENABLE_MASK: filter_enable_mask <= cfg_data;
        REG_SLOW_FILTER_MASK:   slow_filter_mask   <= cfg_data;
        REG_FILTER_TIME_FAST:   filter_time_fast   <= cfg_data;
        REG_FILTER_TIME_SLOW:   filter_time_slow   <= cfg_data;
        REG_LONG_PRESS_MASK:    long_press_mask    <= cfg_data;
        REG_LONG_PRESS_TIME:    long_press_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign advance     = !o_v || out_ch.ready;
  assign in_ch.ready = !s1_v || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // stage 1 entry select and settings
  assign s1_in_range = {1'b0, s1_ch} < CH_LIMIT;
  assign s1_addr     = s1_ch[AW-1:0];
  assign wr          = s1_v && advance && s1_in_range;

  always_comb begin
    if (s1_fwd) begin
      cur = fwd_entry;
    end else if (valid[s1_addr]) begin
      cur = ram_rdata;
    end else begin
      cur = '0;
    end
    level          = s1_pin ^ invert_mask[s1_ch];
    ccfg.filter_en = filter_enable_mask[s1_ch];
    ccfg.limit     = slow_filter_mask[s1_ch] ? filter_time_slow : filter_time_fast;
    ccfg.hold      = long_press_mask[s1_ch] ? long_press_time : '0;
  end

  mcdb_update u_update (
    .cur   (cur),
    .level (level),
    .now   (s1_now),
    .ccfg  (ccfg),
    .nxt   (nxt),
    .edges (edges)
  );

  // per-channel state ram
  mcdb_ram #(
    .WIDTH ($bits(mcdb_entry_t)),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (s1_addr),
    .wdata (nxt),
    .re    (in_xfer),
    .raddr (in_ch.channel[AW-1:0]),
    .rdata (ram_rdata)
  );

  // valid flags and forwarding copy of the last write
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr) begin
      valid[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      fwd_entry <= nxt;
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ch  <= in_ch.channel;
      s1_pin <= in_ch.pin_level;
      s1_now <= in_ch.now_ms;
      s1_fwd <= wr && (s1_ch == in_ch.channel);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (advance) begin
      o_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v && advance) begin
      o_ch   <= s1_ch;
      o_q    <= s1_in_range & nxt.debounced_level;
      o_lp   <= s1_in_range & nxt.long_press_flag;
      o_rise <= s1_in_range & edges.rise;
      o_fall <= s1_in_range & edges.fall;
    end
  end

  assign out_ch.valid           = o_v;
  assign out_ch.out_channel     = o_ch;
  assign out_ch.qualified_level = o_q;
  assign out_ch.long_pressed    = o_lp;
  assign out_ch.rising_edge     = o_rise;
  assign out_ch.falling_edge    = o_fall;

endmodule
